// File: hw/rtl/otw_pkg.sv
// Shared types and constants for the single-wire temperature reader.
// Holds the sequencer phase codes, register indexes, reset values and result record.
// No dependencies.
package otw_pkg;

  localparam int CFG_W = 20;

  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;

  localparam logic [9:0]  RST_LOW_INIT    = 10'd480;
  localparam logic [9:0]  PRES_SAMP_INIT  = 10'd75;
  localparam logic [9:0]  RST_REC_INIT    = 10'd10;
  localparam logic [7:0]  WR_HOLD_INIT    = 8'd60;
  localparam logic [7:0]  WR_REL_INIT     = 8'd16;
  localparam logic [7:0]  RD_SAMP_INIT    = 8'd5;
  localparam logic [7:0]  RD_TAIL_INIT    = 8'd55;
  localparam logic [19:0] CONV_WAIT_INIT  = 20'd750000;

  // Sequence steps with a special meaning.
  localparam logic [3:0] STEP_CONVERT  = 4'd2;
  localparam logic [3:0] STEP_READ_PAD = 4'd6;
  localparam logic [3:0] STEP_LOW_BYTE = 4'd7;
  localparam logic [3:0] STEP_HIGH_BYTE = 4'd8;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRES_SAMPLE   = 3'd1,
    REG_RESET_REC     = 3'd2,
    REG_WRITE_HOLD    = 3'd3,
    REG_WRITE_RELEASE = 3'd4,
    REG_READ_SAMPLE   = 3'd5,
    REG_READ_TAIL     = 3'd6,
    REG_CONVERT_WAIT  = 3'd7
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_START = 4'd4,
    PH_WR_HOLD  = 4'd5,
    PH_WR_REC   = 4'd6,
    PH_RD_START = 4'd7,
    PH_RD_WAIT  = 4'd8,
    PH_RD_TAIL  = 4'd9,
    PH_CONV     = 4'd10
  } phase_t;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [9:0]  presence_sample_us;
    logic [9:0]  reset_recovery_us;
    logic [7:0]  write_hold_us;
    logic [7:0]  write_release_us;
    logic [7:0]  read_sample_us;
    logic [7:0]  read_tail_us;
    logic [19:0] convert_wait_us;
  } cfg_t;

  typedef struct packed {
    logic        line_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        no_device;
    logic [15:0] temp_magnitude;
    logic        temp_negative;
  } res_t;

  function automatic logic [7:0] command_for(input logic [3:0] step);
    logic [7:0] cmd;
    if (step == STEP_CONVERT) begin
      cmd = CMD_CONVERT;
    end else if (step == STEP_READ_PAD) begin
      cmd = CMD_READ_PAD;
    end else begin
      cmd = CMD_SKIP_ROM;
    end
    return cmd;
  endfunction

endpackage

// File: hw/rtl/one_wire_temp_sensor_reader.sv
// Single-wire bus master that reads one temperature sample per start request. Each
// accepted input request is one microsecond tick with the sampled bus level, and it
// yields exactly one result request in the next cycle: the line drive for that tick,
// busy/done/no-device status and the last temperature (magnitude plus sign). The
// block takes one tick per clock cycle; the sequencer state advances in a single
// registered pass, and input is held off only while a result waits on a stalled
// output register. Durations are set through the register port and count in ticks.
//
// Top level: register file, handshakes and result register. Uses otw_pkg, otw_seq.
module one_wire_temp_sensor_reader
  import otw_pkg::*;
#(
  parameter int TIMER_WIDTH = 20
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic        bus_in,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        line_pull_low,
  output logic        busy_res,
  output logic        done_res,
  output logic        no_device,
  output logic [15:0] temp_magnitude,
  output logic        temp_negative
);

  cfg_t       cfg;
  reg_index_t reg_sel;
  logic       cfg_write;
  logic       accept;
  res_t       res;
  res_t       res_out;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[4:2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us       <= RST_LOW_INIT;
      cfg.presence_sample_us <= PRES_SAMP_INIT;
      cfg.reset_recovery_us  <= RST_REC_INIT;
      cfg.write_hold_us      <= WR_HOLD_INIT;
      cfg.write_release_us   <= WR_REL_INIT;
      cfg.read_sample_us     <= RD_SAMP_INIT;
      cfg.read_tail_us       <= RD_TAIL_INIT;
      cfg.convert_wait_us    <= CONV_WAIT_INIT;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_RESET_LOW:     cfg.reset_low_us       <= pwdata[9:0];
        REG_PRES_SAMPLE:   cfg.presence_sample_us <= pwdata[9:0];
        REG_RESET_REC:     cfg.reset_recovery_us  <= pwdata[9:0];
        REG_WRITE_HOLD:    cfg.write_hold_us      <= pwdata[7:0];
        REG_WRITE_RELEASE: cfg.write_release_us   <= pwdata[7:0];
        REG_READ_SAMPLE:   cfg.read_sample_us     <= pwdata[7:0];
        REG_READ_TAIL:     cfg.read_tail_us       <= pwdata[7:0];
        REG_CONVERT_WAIT:  cfg.convert_wait_us    <= pwdata[19:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RESET_LOW:     prdata = 32'(cfg.reset_low_us);
      REG_PRES_SAMPLE:   prdata = 32'(cfg.presence_sample_us);
      REG_RESET_REC:     prdata = 32'(cfg.reset_recovery_us);
      REG_WRITE_HOLD:    prdata = 32'(cfg.write_hold_us);
      REG_WRITE_RELEASE: prdata = 32'(cfg.write_release_us);
      REG_READ_SAMPLE:   prdata = 32'(cfg.read_sample_us);
      REG_READ_TAIL:     prdata = 32'(cfg.read_tail_us);
      REG_CONVERT_WAIT:  prdata = 32'(cfg.convert_wait_us);
    endcase
  end

  // A new tick is taken whenever the result register is free or being emptied.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  otw_seq #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (accept),
    .req     (req_type),
    .bus     (bus_in),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_out <= res;
    end
  end

  assign line_pull_low  = res_out.line_pull_low;
  assign busy_res       = res_out.busy_res;
  assign done_res       = res_out.done_res;
  assign no_device      = res_out.no_device;
  assign temp_magnitude = res_out.temp_magnitude;
  assign temp_negative  = res_out.temp_negative;

`ifndef SYNTHESIS
  // Every accepted tick leaves a result waiting on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no result");

  // A waiting result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !accept)
    else $error("input taken while result stalled");

  // Done always reports an idle sequencer.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while busy");
`endif

endmodule

// File: hw/rtl/otw_seq.sv
// Bus sequencer for the single-wire temperature reader: phase machine, slot timer,
// byte shifter and result register, advanced once per accepted tick. Uses otw_pkg.
module otw_seq
  import otw_pkg::*;
#(
  parameter int TIMER_WIDTH = 20
) (
  input  logic clk,
  input  logic rst,
  input  logic step_en,
  input  logic req,
  input  logic bus,
  input  cfg_t cfg,
  output res_t res
);

  localparam int LW = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  phase_t                  phase, phase_next;
  logic [3:0]              sequence_step, sequence_step_next;
  logic [TIMER_WIDTH-1:0]  time_count, time_count_next;
  logic [2:0]              bit_position, bit_position_next;
  logic [7:0]              shift_byte, shift_byte_next;
  logic [7:0]              first_byte, first_byte_next;
  logic [16:0]             result_hold, result_hold_next;

  logic [CFG_W-1:0]        dur_raw;
  logic [LW-1:0]           dur_ext;
  logic [LW-1:0]           timer_max;
  logic [TIMER_WIDTH-1:0]  seg_len;
  logic [TIMER_WIDTH-1:0]  time_inc;
  logic                    seg_done;
  logic                    enter;
  logic [3:0]              enter_step;
  phase_t                  enter_phase;
  logic                    done, nodev, pull;
  logic [15:0]             raw;
  logic [15:0]             raw_neg;
  logic [7:0]              cmd;

  function automatic phase_t step_phase(input logic [3:0] step);
    phase_t ph;
    unique case (step)
      4'd0, 4'd4:             ph = PH_RST_LOW;
      4'd1, 4'd2, 4'd5, 4'd6: ph = PH_WR_START;
      4'd3:                   ph = PH_CONV;
      4'd7, 4'd8:             ph = PH_RD_START;
      default:                ph = PH_IDLE;
    endcase
    return ph;
  endfunction

  // Segment length of the current phase: zero counts as one tick, and anything past
  // the timer range saturates.
  always_comb begin
    unique case (phase)
      PH_RST_LOW:  dur_raw = CFG_W'(cfg.reset_low_us);
      PH_RST_WAIT: dur_raw = CFG_W'(cfg.presence_sample_us);
      PH_RST_REC:  dur_raw = CFG_W'(cfg.reset_recovery_us);
      PH_WR_HOLD:  dur_raw = CFG_W'(cfg.write_hold_us);
      PH_WR_REC:   dur_raw = CFG_W'(cfg.write_release_us);
      PH_RD_WAIT:  dur_raw = CFG_W'(cfg.read_sample_us);
      PH_RD_TAIL:  dur_raw = CFG_W'(cfg.read_tail_us);
      PH_CONV:     dur_raw = cfg.convert_wait_us;
      default:     dur_raw = CFG_W'(1);
    endcase
    dur_ext   = (dur_raw == '0) ? LW'(1) : LW'(dur_raw);
    timer_max = LW'({TIMER_WIDTH{1'b1}});
    seg_len   = (dur_ext > timer_max) ? timer_max[TIMER_WIDTH-1:0]
                                      : dur_ext[TIMER_WIDTH-1:0];
  end

  assign time_inc = time_count + TIMER_WIDTH'(1);
  assign seg_done = (time_inc >= seg_len);

  // Raw reading is high byte from the shifter, low byte from the first read.
  assign raw     = {shift_byte, first_byte};
  assign raw_neg = 16'h0000 - raw;

  assign cmd = command_for(sequence_step);

  // Next state.
  always_comb begin
    phase_next         = phase;
    sequence_step_next = sequence_step;
    time_count_next    = time_count;
    bit_position_next  = bit_position;
    shift_byte_next    = shift_byte;
    first_byte_next    = first_byte;
    result_hold_next   = result_hold;
    done               = 1'b0;
    nodev              = 1'b0;
    enter              = 1'b0;
    enter_step         = sequence_step + 4'd1;

    if (phase == PH_IDLE) begin
      if (req) begin
        enter      = 1'b1;
        enter_step = 4'd0;
      end
    end else begin
      time_count_next = seg_done ? '0 : time_inc;
      if (seg_done) begin
        unique case (phase)
          PH_RST_LOW:  phase_next = PH_RST_WAIT;
          PH_RST_WAIT: begin
            if (bus) begin
              phase_next       = PH_IDLE;
              done             = 1'b1;
              nodev            = 1'b1;
              result_hold_next = '0;
            end else begin
              phase_next = PH_RST_REC;
            end
          end
          PH_RST_REC:  enter = 1'b1;
          PH_WR_START: phase_next = PH_WR_HOLD;
          PH_WR_HOLD:  phase_next = PH_WR_REC;
          PH_WR_REC: begin
            if (bit_position == 3'd7) begin
              enter = 1'b1;
            end else begin
              bit_position_next = bit_position + 3'd1;
              phase_next        = PH_WR_START;
            end
          end
          PH_RD_START: phase_next = PH_RD_WAIT;
          PH_RD_WAIT: begin
            if (bus) begin
              shift_byte_next = shift_byte | (8'd1 << bit_position);
            end
            phase_next = PH_RD_TAIL;
          end
          PH_RD_TAIL: begin
            if (bit_position == 3'd7) begin
              if (sequence_step == STEP_LOW_BYTE) begin
                first_byte_next = shift_byte;
              end else begin
                result_hold_next = raw[15] ? {1'b1, raw_neg} : {1'b0, raw};
              end
              enter = 1'b1;
            end else begin
              bit_position_next = bit_position + 3'd1;
              phase_next        = PH_RD_START;
            end
          end
          PH_CONV: enter = 1'b1;
          default: phase_next = PH_IDLE;
        endcase
      end
    end

    enter_phase = step_phase(enter_step);
    if (enter) begin
      sequence_step_next = enter_step;
      time_count_next    = '0;
      bit_position_next  = '0;
      phase_next         = enter_phase;
      if (enter_step == STEP_LOW_BYTE || enter_step == STEP_HIGH_BYTE) begin
        shift_byte_next = '0;
      end
      if (enter_phase == PH_IDLE) begin
        done = 1'b1;
      end
    end
  end

  // Line drive for this tick.
  always_comb begin
    unique case (phase)
      PH_RST_LOW, PH_WR_START, PH_RD_START: pull = 1'b1;
      PH_WR_HOLD: pull = ~cmd[bit_position];
      default:    pull = 1'b0;
    endcase
  end

  always_comb begin
    res.line_pull_low  = pull;
    res.busy_res       = (phase_next != PH_IDLE);
    res.done_res       = done;
    res.no_device      = nodev;
    res.temp_magnitude = result_hold_next[15:0];
    res.temp_negative  = result_hold_next[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      sequence_step <= '0;
      time_count    <= '0;
      bit_position  <= '0;
      shift_byte    <= '0;
      first_byte    <= '0;
      result_hold   <= '0;
    end else if (step_en) begin
      phase         <= phase_next;
      sequence_step <= sequence_step_next;
      time_count    <= time_count_next;
      bit_position  <= bit_position_next;
      shift_byte    <= shift_byte_next;
      first_byte    <= first_byte_next;
      result_hold   <= result_hold_next;
    end
  end

`ifndef SYNTHESIS
  // The timer is always cleared while the bus is idle.
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> time_count == '0)
    else $error("timer not cleared in idle");

  // A finished or aborted sequence leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    step_en && done |=> phase == PH_IDLE)
    else $error("sequencer still busy after done");

  // A missing device is only reported as part of an abort, with the result cleared.
  a_nodev_clears: assert property (@(posedge clk) disable iff (rst)
    step_en && nodev |=> done == 1'b0 || phase == PH_IDLE && result_hold == '0)
    else $error("no-device abort left a result");

  // A tick that is not taken leaves the sequencer untouched.
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !step_en |=> $stable(phase) && $stable(time_count) && $stable(result_hold))
    else $error("sequencer state moved without an accepted tick");
`endif

endmodule
